// ----- rtl/ster_pkg.sv -----
// shared types and constants of the sensor threshold event reporter
`default_nettype none

package ster_pkg;

    // zone codes
    typedef enum logic [1:0] {
        ZONE_NONE     = 2'd0,
        ZONE_BELOW    = 2'd1,
        ZONE_IN_RANGE = 2'd2,
        ZONE_ABOVE    = 2'd3
    } zone_t;

    // result kinds
    typedef enum logic {
        KIND_EVENT  = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    // input actions
    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOWER    = 3'd0,
        CFG_UPPER    = 3'd1,
        CFG_HYST     = 3'd2,
        CFG_MIN_TIME = 3'd3,
        CFG_MAX_TIME = 3'd4
    } cfg_index_t;

    localparam int VALUE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // work for the back end: up to one event and one report
    typedef struct packed {
        logic                has_event;
        zone_t               event_zone;
        logic                has_report;
        zone_t               report_zone;
        logic [VALUE_W-1:0]  report_value;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ster_if.sv -----
// request channel interfaces: sample input, result output, configuration write
`default_nettype none

interface ster_in_if;
    import ster_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [VALUE_W-1:0]  sample_value;
    modport source (output valid, output action, output sample_value, input ready);
    modport sink   (input valid, input action, input sample_value, output ready);
endinterface

interface ster_out_if;
    import ster_pkg::*;
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [1:0]          zone;
    logic [VALUE_W-1:0]  report_value;
    logic                last_of_run;
    modport source (output valid, output result_kind, output zone, output report_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input zone, input report_value,
                    input last_of_run, output ready);
endinterface

interface ster_cfg_if;
    import ster_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ster_front.sv -----
// front end: configuration registers, zone classification, report timing
`default_nettype none

module ster_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ster_cfg_if.sink           cfg_ch,
    ster_in_if.sink            in_ch,
    input  wire logic          q_full,
    output logic               push,
    output ster_pkg::cmd_t     cmd
);
    import ster_pkg::*;

    // configuration registers
    logic signed [15:0] lower_reg, lower_next;
    logic signed [15:0] upper_reg, upper_next;
    logic [7:0]         hyst_reg, hyst_next;
    logic [7:0]         min_time_reg, min_time_next;
    logic [7:0]         max_time_reg, max_time_next;

    // thresholds widened by the hysteresis, kept in step with the registers
    logic [11:0]        h_reg, h_next;
    logic signed [17:0] lo_m_h_reg, lo_m_h_next;
    logic signed [17:0] lo_p_h_reg, lo_p_h_next;
    logic signed [17:0] hi_m_h_reg, hi_m_h_next;
    logic signed [17:0] hi_p_h_reg, hi_p_h_next;

    // block state
    zone_t              cur_zone_reg, cur_zone_next;
    zone_t              prev_zone_reg, prev_zone_next;
    logic [15:0]        lrv_reg, lrv_next;
    zone_t              lrz_reg, lrz_next;
    logic [15:0]        timer_reg, timer_next;

    logic               cfg_wr;
    logic               in_acc;
    logic signed [17:0] v_ext;
    logic signed [17:0] lo_ext;
    logic signed [17:0] hi_ext;
    logic signed [17:0] h_ext;
    zone_t              raw_zone;
    logic               take;
    zone_t              new_zone;
    logic               zone_changed;
    logic [15:0]        timer_inc;
    logic signed [16:0] diff;
    logic [16:0]        diff_abs;
    logic               do_report;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !q_full;
    assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
    assign in_acc       = in_ch.valid && in_ch.ready;

    // register writes
    always_comb
    begin
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        hyst_next     = hyst_reg;
        min_time_next = min_time_reg;
        max_time_next = max_time_reg;
        if (cfg_wr)
        begin
            case (cfg_ch.index)
                CFG_LOWER:    lower_next    = cfg_ch.data;
                CFG_UPPER:    upper_next    = cfg_ch.data;
                CFG_HYST:     hyst_next     = cfg_ch.data[7:0];
                CFG_MIN_TIME: min_time_next = cfg_ch.data[7:0];
                CFG_MAX_TIME: max_time_next = cfg_ch.data[7:0];
                default:      ;
            endcase
        end
    end

    // hysteresis in hundredths and the four widened bounds
    always_comb
    begin
        h_next      = {1'b0, hyst_next, 3'b000} + {3'b000, hyst_next, 1'b0};
        h_ext       = $signed({6'b000000, h_next});
        lo_ext      = {{2{lower_next[15]}}, lower_next};
        hi_ext      = {{2{upper_next[15]}}, upper_next};
        lo_m_h_next = lo_ext - h_ext;
        lo_p_h_next = lo_ext + h_ext;
        hi_m_h_next = hi_ext - h_ext;
        hi_p_h_next = hi_ext + h_ext;
    end

    // zone classification with hysteresis
    always_comb
    begin
        v_ext = {{2{in_ch.sample_value[15]}}, in_ch.sample_value};
        if (v_ext < $signed({{2{lower_reg[15]}}, lower_reg}))
            raw_zone = ZONE_BELOW;
        else if (v_ext >= $signed({{2{upper_reg[15]}}, upper_reg}))
            raw_zone = ZONE_ABOVE;
        else
            raw_zone = ZONE_IN_RANGE;

        take = (h_reg == 12'd0) || (cur_zone_reg == ZONE_NONE) || (raw_zone != prev_zone_reg)
            || ((raw_zone == ZONE_BELOW) && (v_ext < lo_m_h_reg))
            || ((raw_zone == ZONE_ABOVE) && (v_ext > hi_p_h_reg))
            || ((raw_zone == ZONE_IN_RANGE) && ((v_ext > lo_p_h_reg) || (v_ext < hi_m_h_reg)));
        new_zone     = take ? raw_zone : cur_zone_reg;
        zone_changed = (new_zone != cur_zone_reg);
    end

    // report timer and value movement
    always_comb
    begin
        timer_inc = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
        diff      = $signed({lrv_reg[15], lrv_reg}) - $signed({in_ch.sample_value[15],
                                                                in_ch.sample_value});
        diff_abs  = diff[16] ? 17'(-diff) : 17'(diff);
        do_report = (timer_inc > {8'd0, min_time_reg})
            && ((timer_inc > {8'd0, max_time_reg}) || (diff_abs > {5'd0, h_reg}));
    end

    // state update and command to the back end
    always_comb
    begin
        cur_zone_next  = cur_zone_reg;
        prev_zone_next = prev_zone_reg;
        lrv_next       = lrv_reg;
        lrz_next       = lrz_reg;
        timer_next     = timer_reg;
        push           = 1'b0;
        cmd            = '0;
        if (cfg_wr && (cfg_ch.index == CFG_MAX_TIME))
            timer_next = {8'd0, cfg_ch.data[7:0]};
        if (in_acc)
        begin
            if (in_ch.action == ACT_READ)
            begin
                push             = 1'b1;
                cmd.has_report   = 1'b1;
                cmd.report_zone  = lrz_reg;
                cmd.report_value = lrv_reg;
            end
            else
            begin
                if (zone_changed)
                begin
                    prev_zone_next = cur_zone_reg;
                    cur_zone_next  = new_zone;
                end
                cmd.has_event  = zone_changed && (cur_zone_reg != ZONE_NONE);
                cmd.event_zone = new_zone;
                if (do_report)
                begin
                    timer_next       = 16'd0;
                    lrv_next         = in_ch.sample_value;
                    lrz_next         = new_zone;
                    cmd.has_report   = 1'b1;
                    cmd.report_zone  = new_zone;
                    cmd.report_value = in_ch.sample_value;
                end
                else
                begin
                    timer_next = timer_inc;
                end
                push = cmd.has_event || cmd.has_report;
            end
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg     <= '0;
            upper_reg     <= '0;
            hyst_reg      <= '0;
            min_time_reg  <= '0;
            max_time_reg  <= '0;
            h_reg         <= '0;
            lo_m_h_reg    <= '0;
            lo_p_h_reg    <= '0;
            hi_m_h_reg    <= '0;
            hi_p_h_reg    <= '0;
            cur_zone_reg  <= ZONE_NONE;
            prev_zone_reg <= ZONE_NONE;
            lrv_reg       <= '0;
            lrz_reg       <= ZONE_NONE;
            timer_reg     <= '0;
        end
        else
        begin
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            hyst_reg      <= hyst_next;
            min_time_reg  <= min_time_next;
            max_time_reg  <= max_time_next;
            h_reg         <= h_next;
            lo_m_h_reg    <= lo_m_h_next;
            lo_p_h_reg    <= lo_p_h_next;
            hi_m_h_reg    <= hi_m_h_next;
            hi_p_h_reg    <= hi_p_h_next;
            cur_zone_reg  <= cur_zone_next;
            prev_zone_reg <= prev_zone_next;
            lrv_reg       <= lrv_next;
            lrz_reg       <= lrz_next;
            timer_reg     <= timer_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ster_queue.sv -----
// command queue between front and back end
`default_nettype none

module ster_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ster_pkg::cmd_t   push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output ster_pkg::cmd_t        head
);
    import ster_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // no overflow, no underflow
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/ster_back.sv -----
// back end: expands commands into results behind an output register
`default_nettype none

module ster_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire ster_pkg::cmd_t   head,
    output logic                  pop,
    ster_out_if.source            out_ch
);
    import ster_pkg::*;

    logic               valid_reg, valid_next;
    logic               phase_reg, phase_next;
    logic               kind_reg, kind_next;
    logic [1:0]         zone_reg, zone_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic               fire;

    assign out_ch.valid        = valid_reg;
    assign out_ch.result_kind  = kind_reg;
    assign out_ch.zone         = zone_reg;
    assign out_ch.report_value = value_reg;
    assign out_ch.last_of_run  = last_reg;

    // output register loads from the queue head when it is empty or being drained
    assign fire = !q_empty && (!valid_reg || out_ch.ready);

    // event first, then report
    always_comb
    begin
        valid_next = valid_reg && !out_ch.ready;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        zone_next  = zone_reg;
        value_next = value_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (fire)
        begin
            valid_next = 1'b1;
            if (head.has_event && !phase_reg)
            begin
                kind_next  = KIND_EVENT;
                zone_next  = head.event_zone;
                value_next = '0;
                last_next  = !head.has_report;
                phase_next = head.has_report;
                pop        = !head.has_report;
            end
            else
            begin
                kind_next  = KIND_REPORT;
                zone_next  = head.report_zone;
                value_next = head.report_value;
                last_next  = 1'b1;
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        zone_reg  <= zone_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    // split command stays at the head with its report pending
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!q_empty && head.has_event && head.has_report))
        else $error("pending report without matching queue head");
    a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> valid_reg)
        else $error("pending report while output register empty");
    a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_EVENT)) |-> ((value_reg == '0) && (zone_reg != ZONE_NONE)))
        else $error("malformed zone change event");

endmodule

`default_nettype wire

// ----- rtl/sensor_threshold_event_reporter.sv -----
// Window comparator with hysteresis and timed status reports.
// Channels: in_ch takes a request (action, sample_value); action 0 classifies a
// sample, action 1 reads back the last reported value and zone. out_ch gives one
// request per result (result_kind, zone, report_value, last_of_run); a sample
// causes zero, one or two results, a zone change event ahead of a status report.
// cfg_ch writes register index/data; it is always ready. The user must see that
// it is written only while the block is idle; the block does not enforce this.
// Writing max_report_time also loads the report timer. An accepted item passes
// through the queue and then the output register before its first result is
// valid. The front end takes one item per cycle while the queue is not full and
// pushes its work into a QUEUE_DEPTH entry queue; the back end drives one result
// per cycle through its output register while out_ch.ready is high, so the
// sustained rate is one result per cycle; the two results of an item leave in turn.
// Stall: while out_ch.ready is low the output register holds, the queue fills,
// and in_ch.ready drops once the queue is full.
// Reset: all front-end registers, zones, the timer and the last reported value clear to
// zero; the queue and output register empty.
`default_nettype none

module sensor_threshold_event_reporter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ster_cfg_if.sink   cfg_ch,
    ster_in_if.sink    in_ch,
    ster_out_if.source out_ch
);
    import ster_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    logic pop;
    cmd_t head;

    // classification and state
    ster_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push),
        .cmd    (push_cmd)
    );

    // decoupling queue
    ster_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    // result emission
    ster_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire
